FILE: rtl/utp_pkg.sv
// Package with character codes, sizes and the hex digit decoder for the UUID text parser.
`default_nettype none

package utp_pkg;

	localparam logic [7:0] CHAR_LBRACE = 8'h7B;
	localparam logic [7:0] CHAR_RBRACE = 8'h7D;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;

	localparam int OCTETS      = 16;
	localparam int COUNT_W     = $clog2(OCTETS + 1);
	localparam int UUID_W      = 8 * OCTETS;
	localparam int HALF_W      = UUID_W / 2;
	localparam int FIRST_DASH  = 4;

	localparam logic [COUNT_W-1:0] OCTET_FULL  = COUNT_W'(OCTETS);
	localparam logic [COUNT_W-1:0] OCTET_DASH0 = COUNT_W'(FIRST_DASH);
	localparam logic [COUNT_W-1:0] OCTET_DASH1 = COUNT_W'(6);
	localparam logic [COUNT_W-1:0] OCTET_DASH2 = COUNT_W'(8);
	localparam logic [COUNT_W-1:0] OCTET_DASH3 = COUNT_W'(10);

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.is_hex = 1'b0;
		d.value  = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.is_hex = 1'b1;
			d.value  = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d.is_hex = 1'b1;
			d.value  = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d.is_hex = 1'b1;
			d.value  = 4'(c - 8'h37);
		end
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/uuid_text_parser.sv
// Top level of the streaming UUID text parser: input register, parse state and result register.
`default_nettype none

// The parser takes one character of UUID text per beat and accepts a new beat in
// every cycle unless the input stalls, as described below. A beat is registered
// at the input and decoded against the parse position, and a beat flagged
// last_char loads the result register. Beats without last_char produce nothing.
// The result register decouples the sides; the input stalls only when a last
// character meets a result that is still waiting on out_ready. After each last
// character the parse state returns to its reset value, so strings can follow
// each other without gaps.
module uuid_text_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             parse_ok,
	output logic [63:0]      uuid_high,
	output logic [63:0]      uuid_low
);

	localparam int CW = utp_pkg::COUNT_W;
	localparam int UW = utp_pkg::UUID_W;
	localparam int HW = utp_pkg::HALF_W;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;

	logic          start_q, braced_q, dashed_q, second_q, failed_q, dash_taken_q;
	logic [CW-1:0] count_q;
	logic [3:0]    upper_q;
	logic [UW-1:0] store_q;

	logic          start_n, braced_n, dashed_n, second_n, failed_n, dash_taken_n;
	logic [CW-1:0] count_n;
	logic [3:0]    upper_n;
	logic [UW-1:0] store_n;

	logic          out_valid_q, parse_ok_q;
	logic [HW-1:0] uuid_high_q, uuid_low_q;

	logic          advance, step, consumed, ok_n, dash_slot;
	logic [3:0]    octet_idx;
	utp_pkg::hex_digit_t digit;

	assign advance  = !(valid_s1 && last_s1 && out_valid_q && !out_ready);
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign digit     = utp_pkg::hex_decode(char_s1);
	assign octet_idx = count_q[3:0];
	assign dash_slot = count_q == utp_pkg::OCTET_DASH1 || count_q == utp_pkg::OCTET_DASH2
		|| count_q == utp_pkg::OCTET_DASH3;

	always_comb begin
		start_n      = start_q;
		braced_n     = braced_q;
		dashed_n     = dashed_q;
		second_n     = second_q;
		failed_n     = failed_q;
		dash_taken_n = dash_taken_q;
		count_n      = count_q;
		upper_n      = upper_q;
		store_n      = store_q;
		consumed     = 1'b0;

		if (start_q) begin
			start_n = 1'b0;
			if (char_s1 == utp_pkg::CHAR_LBRACE) begin
				braced_n = 1'b1;
				consumed = 1'b1;
			end
		end

		if (!consumed) begin
			if (braced_n && last_s1) begin
				if (char_s1 != utp_pkg::CHAR_RBRACE) begin
					failed_n = 1'b1;
				end
			end else if (!failed_q && count_q < utp_pkg::OCTET_FULL) begin
				if (!second_q) begin
					if (count_q == utp_pkg::OCTET_DASH0 && !dashed_q
						&& char_s1 == utp_pkg::CHAR_DASH) begin
						dashed_n = 1'b1;
					end else if (dashed_q && !dash_taken_q && dash_slot) begin
						if (char_s1 == utp_pkg::CHAR_DASH) begin
							dash_taken_n = 1'b1;
						end else begin
							failed_n = 1'b1;
						end
					end else if (!digit.is_hex) begin
						failed_n = 1'b1;
					end else begin
						upper_n  = digit.value;
						second_n = 1'b1;
					end
				end else if (!digit.is_hex) begin
					failed_n = 1'b1;
				end else begin
					store_n[{~octet_idx, 3'b000} +: 8] = {upper_q, digit.value};
					count_n      = count_q + 1'b1;
					second_n     = 1'b0;
					dash_taken_n = 1'b0;
				end
			end
		end

		ok_n = !failed_n && count_n == utp_pkg::OCTET_FULL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= 1'b1;
			braced_q     <= 1'b0;
			dashed_q     <= 1'b0;
			second_q     <= 1'b0;
			failed_q     <= 1'b0;
			dash_taken_q <= 1'b0;
			count_q      <= '0;
			upper_q      <= '0;
			store_q      <= '0;
		end else if (step) begin
			if (last_s1) begin
				start_q      <= 1'b1;
				braced_q     <= 1'b0;
				dashed_q     <= 1'b0;
				second_q     <= 1'b0;
				failed_q     <= 1'b0;
				dash_taken_q <= 1'b0;
				count_q      <= '0;
				upper_q      <= '0;
				store_q      <= '0;
			end else begin
				start_q      <= start_n;
				braced_q     <= braced_n;
				dashed_q     <= dashed_n;
				second_q     <= second_n;
				failed_q     <= failed_n;
				dash_taken_q <= dash_taken_n;
				count_q      <= count_n;
				upper_q      <= upper_n;
				store_q      <= store_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			parse_ok_q  <= ok_n;
			uuid_high_q <= ok_n ? store_n[UW-1 -: HW] : '0;
			uuid_low_q  <= ok_n ? store_n[HW-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign parse_ok  = parse_ok_q;
	assign uuid_high = uuid_high_q;
	assign uuid_low  = uuid_low_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !parse_ok) |-> (uuid_high == '0 && uuid_low == '0))
		else $error("Failed parse gave a nonzero value.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= utp_pkg::OCTET_FULL)
		else $error("Octet count ran past the end.");

	a_nibble_count: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> count_q < utp_pkg::OCTET_FULL)
		else $error("Pending nibble after the last octet.");

	a_dash_taken: assert property (@(posedge clk) disable iff (!arst_n)
		dash_taken_q |-> dashed_q)
		else $error("Dash consumed in an undashed string.");

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> (start_q && count_q == '0 && !failed_q))
		else $error("Parse state not cleared after the last character.");

endmodule

`default_nettype wire
